// ===== src/dgtp_pkg.sv =====
// ---------------------------------------------------------------------------
// dgtp_pkg
// Shared types and constants for the delimited grid tile parser.
// ---------------------------------------------------------------------------
package dgtp_pkg;

    localparam int COORD_BITS = 24;
    localparam int OUT_COORD_BITS = 24;
    localparam int VALUE_BITS = 32;
    localparam int CHAR_BITS = 8;

    localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_BITS-1:0] CHAR_NUL = 8'd0;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS = 8'd43;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'd57;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB = 8'd9;
    localparam logic [CHAR_BITS-1:0] CHAR_CR = 8'd13;

    typedef enum logic [1:0] {
        REG_STEP_X     = 2'd0,
        REG_STEP_Y     = 2'd1,
        REG_SEPARATOR  = 2'd2,
        REG_EMPTY_TYPE = 2'd3
    } cfg_addr_t;

    localparam logic [7:0] STEP_X_RESET = 8'd16;
    localparam logic [7:0] STEP_Y_RESET = 8'd16;
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [VALUE_BITS-1:0] EMPTY_TYPE_RESET = '0;

    typedef struct packed {
        logic                 feed;
        logic                 clear;
        logic [CHAR_BITS-1:0] ch;
    } field_ctrl_t;

    typedef logic [COORD_BITS-1:0] coord_t;

    function automatic coord_t coord_sat_add(input coord_t a, input logic [7:0] b);
        logic [COORD_BITS:0] sum;
        begin
            sum = {1'b0, a} + (COORD_BITS+1)'(b);
            coord_sat_add = sum[COORD_BITS] ? {COORD_BITS{1'b1}} : sum[COORD_BITS-1:0];
        end
    endfunction

    function automatic logic [OUT_COORD_BITS-1:0] coord_out(input coord_t c);
        logic [31:0] wide;
        begin
            wide = 32'(c);
            coord_out = wide[OUT_COORD_BITS-1:0];
        end
    endfunction

endpackage

// ===== src/dgtp_field_conv.sv =====
// ---------------------------------------------------------------------------
// dgtp_field_conv
// Per-field decimal conversion: whitespace skip, sign, digit accumulate.
// ---------------------------------------------------------------------------
module dgtp_field_conv
    import dgtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  field_ctrl_t           ctrl,
    output logic [VALUE_BITS-1:0] field_v,
    output logic                  nonempty
);

    typedef enum logic [1:0] {
        PH_WS   = 2'd0,
        PH_NUM  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  neg_reg, neg_next;
    phase_t                phase_reg, phase_next;
    logic                  nonempty_reg, nonempty_next;

    logic                  is_digit;
    logic                  is_space;
    logic [VALUE_BITS-1:0] digit_v;
    logic [VALUE_BITS-1:0] times_ten;

    assign is_digit  = (ctrl.ch >= CHAR_ZERO) && (ctrl.ch <= CHAR_NINE);
    assign is_space  = (ctrl.ch == CHAR_SPACE) || ((ctrl.ch >= CHAR_TAB) && (ctrl.ch <= CHAR_CR));
    assign digit_v   = VALUE_BITS'(ctrl.ch - CHAR_ZERO) & VALUE_BITS'(4'hf);
    assign times_ten = (value_reg << 3) + (value_reg << 1);

    always_comb
    begin
        value_next    = value_reg;
        neg_next      = neg_reg;
        phase_next    = phase_reg;
        nonempty_next = nonempty_reg;
        if (ctrl.clear)
        begin
            value_next    = '0;
            neg_next      = 1'b0;
            phase_next    = PH_WS;
            nonempty_next = 1'b0;
        end
        else if (ctrl.feed)
        begin
            nonempty_next = 1'b1;
            case (phase_reg)
                PH_WS:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_WS;
                    end
                    else if (ctrl.ch == CHAR_PLUS)
                    begin
                        phase_next = PH_NUM;
                    end
                    else if (ctrl.ch == CHAR_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_NUM;
                    end
                    else if (is_digit)
                    begin
                        value_next = digit_v;
                        phase_next = PH_NUM;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_NUM:
                begin
                    if (is_digit)
                        value_next = times_ten + digit_v;
                    else
                        phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg    <= '0;
            neg_reg      <= 1'b0;
            phase_reg    <= PH_WS;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            value_reg    <= value_next;
            neg_reg      <= neg_next;
            phase_reg    <= phase_next;
            nonempty_reg <= nonempty_next;
        end
    end

    assign field_v  = neg_reg ? (VALUE_BITS'(0) - value_reg) : value_reg;
    assign nonempty = nonempty_reg;

endmodule

// ===== src/delimited_grid_tile_parser_core.sv =====
// ---------------------------------------------------------------------------
// delimited_grid_tile_parser_core
// Parses a byte stream of separator-delimited integers into positioned cells.
// ---------------------------------------------------------------------------
//  channel | dir | signals                      | contents
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | one text byte, end flag
//  m_      | out | m_tvalid m_tready m_tdata    | pos_x, pos_y, block_type
//  cfg_    | in  | cfg_wr_en cfg_addr cfg_wdata | step_x, step_y, separator, empty_type
//
//  One byte per cycle while s_tready is high; each request updates the field
//  state in the cycle it is taken and at most one result lands in the output register.
//  s_tready is low only while the output register is full and not drained.
//  Reset clears field state, positions and loads register defaults.
// ---------------------------------------------------------------------------
module delimited_grid_tile_parser_core
    import dgtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tuser,   // [0] is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [23:0] pos_x, [47:24] pos_y, [79:48] block_type
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    logic [7:0]            step_x_reg;
    logic [7:0]            step_y_reg;
    logic [7:0]            separator_reg;
    logic [VALUE_BITS-1:0] empty_type_reg;

    coord_t col_reg, col_next;
    coord_t row_reg, row_next;

    logic                  out_valid_reg, out_valid_next;
    logic [79:0]           out_data_reg;

    logic                  accept;
    logic                  is_sep;
    logic                  is_nl;
    logic                  emit;
    field_ctrl_t           fctrl;
    logic [VALUE_BITS-1:0] field_v;
    logic                  nonempty;
    logic                  not_empty_type;

    dgtp_field_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (fctrl),
        .field_v  (field_v),
        .nonempty (nonempty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg     <= STEP_X_RESET;
            step_y_reg     <= STEP_Y_RESET;
            separator_reg  <= SEPARATOR_RESET;
            empty_type_reg <= EMPTY_TYPE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr_t'(cfg_addr))
                REG_STEP_X:     step_x_reg     <= cfg_wdata[7:0];
                REG_STEP_Y:     step_y_reg     <= cfg_wdata[7:0];
                REG_SEPARATOR:  separator_reg  <= cfg_wdata[7:0];
                REG_EMPTY_TYPE: empty_type_reg <= cfg_wdata;
                default:        step_x_reg     <= step_x_reg;
            endcase
        end
    end

    assign s_tready       = !out_valid_reg || m_tready;
    assign accept         = s_tvalid && s_tready;
    assign is_sep         = (s_tdata == separator_reg);
    assign is_nl          = (s_tdata == CHAR_NEWLINE);
    assign not_empty_type = (field_v != empty_type_reg);

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        emit        = 1'b0;
        fctrl.feed  = 1'b0;
        fctrl.clear = 1'b0;
        fctrl.ch    = s_tdata;
        if (accept)
        begin
            if (s_tuser)
            begin
                emit        = nonempty && not_empty_type;
                fctrl.clear = 1'b1;
                col_next    = '0;
                row_next    = '0;
            end
            else if (is_sep)
            begin
                emit        = not_empty_type;
                fctrl.clear = 1'b1;
                col_next    = coord_sat_add(col_reg, step_x_reg);
            end
            else if (is_nl)
            begin
                emit        = nonempty && not_empty_type;
                fctrl.clear = 1'b1;
                col_next    = '0;
                row_next    = coord_sat_add(row_reg, step_y_reg);
            end
            else
            begin
                fctrl.feed = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= {field_v, coord_out(row_reg), coord_out(col_reg)};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== dv/tb_delimited_grid_tile_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_delimited_grid_tile_parser_core
// Self-checking bench for the grid parser: streams text bytes and end marks,
// predicts every emitted cell and compares position and value in order.
// Both stream sides idle at random; registers change only while idle.
// ---------------------------------------------------------------------------
module tb_delimited_grid_tile_parser_core;
    import dgtp_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [7:0] CHAR_VT = 8'd11;
    localparam logic [7:0] CHAR_FF = 8'd12;
    localparam logic [7:0] CHAR_SEMI = 8'd59;
    localparam logic [7:0] CHAR_X = 8'd120;

    class grid_scoreboard;
        typedef enum logic [1:0] {SCAN_BLANK, SCAN_DIGITS, SCAN_DONE} scan_t;

        logic [7:0]  step_x;
        logic [7:0]  step_y;
        logic [7:0]  sep;
        logic [31:0] empty_val;
        logic [31:0] acc;
        bit          neg;
        scan_t       scan;
        bit          nonempty;
        coord_t      col;
        coord_t      row;
        logic [79:0] cells[$];
        int          errors;

        function new();
            step_x = STEP_X_RESET;
            step_y = STEP_Y_RESET;
            sep = SEPARATOR_RESET;
            empty_val = EMPTY_TYPE_RESET;
            clear_field();
            col = '0;
            row = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_addr_t a, logic [31:0] v);
            case (a)
                REG_STEP_X:     step_x = v[7:0];
                REG_STEP_Y:     step_y = v[7:0];
                REG_SEPARATOR:  sep = v[7:0];
                REG_EMPTY_TYPE: empty_val = v;
                default:        ;
            endcase
        endfunction

        function void clear_field();
            acc = '0;
            neg = 1'b0;
            scan = SCAN_BLANK;
            nonempty = 1'b0;
        endfunction

        function coord_t bump(coord_t c, logic [7:0] s);
            logic [COORD_BITS:0] t;
            t = {1'b0, c} + {{(COORD_BITS-7){1'b0}}, s};
            if (t > {1'b0, {COORD_BITS{1'b1}}})
                return {COORD_BITS{1'b1}};
            return t[COORD_BITS-1:0];
        endfunction

        function void close_field();
            logic [31:0] v;
            v = neg ? (32'd0 - acc) : acc;
            if (v != empty_val)
                cells.push_back({v, coord_out(row), coord_out(col)});
        endfunction

        function void absorb(logic [7:0] c);
            bit digit;
            digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            nonempty = 1'b1;
            if (scan == SCAN_BLANK)
            begin
                if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                    return;
                else if (c == CHAR_PLUS)
                    scan = SCAN_DIGITS;
                else if (c == CHAR_MINUS)
                begin
                    neg = 1'b1;
                    scan = SCAN_DIGITS;
                end
                else if (digit)
                begin
                    acc = {24'd0, c - CHAR_ZERO};
                    scan = SCAN_DIGITS;
                end
                else
                    scan = SCAN_DONE;
            end
            else if (scan == SCAN_DIGITS)
            begin
                if (digit)
                    acc = acc * 32'd10 + {24'd0, c - CHAR_ZERO};
                else
                    scan = SCAN_DONE;
            end
        endfunction

        function void note_request(logic [7:0] c, logic fin);
            if (fin)
            begin
                if (nonempty)
                    close_field();
                clear_field();
                col = '0;
                row = '0;
            end
            else if (c == sep)
            begin
                close_field();
                col = bump(col, step_x);
                clear_field();
            end
            else if (c == CHAR_NEWLINE)
            begin
                if (nonempty)
                    close_field();
                col = '0;
                row = bump(row, step_y);
                clear_field();
            end
            else
                absorb(c);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_cell(logic [79:0] got);
            logic [79:0] want;
            if (cells.size() == 0)
            begin
                report($sformatf("unexpected cell %h", got));
                return;
            end
            want = cells.pop_front();
            if (got[23:0] != want[23:0])
                report($sformatf("pos_x got %0d want %0d", got[23:0], want[23:0]));
            if (got[47:24] != want[47:24])
                report($sformatf("pos_y got %0d want %0d", got[47:24], want[47:24]));
            if (got[79:48] != want[79:48])
                report($sformatf("block_type got %h want %h", got[79:48], want[79:48]));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_in
    logic        s_tuser;   // [0] is_end
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // [23:0] pos_x, [47:24] pos_y, [79:48] block_type
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    grid_scoreboard sb;
    bit         calm;
    int         items_sent;
    int         stall;
    logic [7:0] cur_sep;

    delimited_grid_tile_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function int pick_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_cell(m_tdata);
    end

    initial
    begin
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                stall = 0;
            else
                stall++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result sink with random back-pressure
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // entered and left at a falling edge
    task send_req(input logic [7:0] ch, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = ch;
        s_tuser = fin;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(s[i], 1'b0);
    endtask

    task send_end();
        send_req(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function logic [7:0] blank_byte();
        case ($urandom_range(0, 4))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            3:       return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    // one mostly well-formed field, usually followed by its terminator
    task send_field();
        int r;
        int nd;
        int term;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 3)) send_req(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        repeat ($urandom_range(0, 2)) send_req(blank_byte(), 1'b0);
        case ($urandom_range(0, 3))
            0:       send_req(CHAR_PLUS, 1'b0);
            1:       send_req(CHAR_MINUS, 1'b0);
            default: ;
        endcase
        nd = $urandom_range(0, 9);
        if (nd == 0)
            nd = 0;
        else if (nd < 8)
            nd = $urandom_range(1, 3);
        else
            nd = $urandom_range(4, 12);
        repeat (nd) send_req(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        if (r >= 92)
        begin
            send_req(r[0] ? CHAR_NUL : CHAR_X, 1'b0);
            send_req(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
        term = $urandom_range(0, 99);
        if (term < 60)
            send_req(cur_sep, 1'b0);
        else if (term < 90)
            send_req(CHAR_NEWLINE, 1'b0);
        else if (term < 95)
            send_end();
    endtask

    task drain();
        s_tvalid = 1'b0;
        while (sb.cells.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_regs(input logic [7:0] sx, input logic [7:0] sy,
                    input logic [7:0] sp, input logic [31:0] ev);
        cfg_addr_t a;
        logic [31:0] v;
        for (int i = 0; i < 4; i++)
        begin
            a = cfg_addr_t'(i);
            case (a)
                REG_STEP_X:    v = {24'($urandom_range(0, 16777215)), sx};
                REG_STEP_Y:    v = {24'($urandom_range(0, 16777215)), sy};
                REG_SEPARATOR: v = {24'($urandom_range(0, 16777215)), sp};
                default:       v = ev;
            endcase
            cfg_wr_en = 1'b1;
            cfg_addr = a;
            cfg_wdata = v;
            sb.set_reg(a, v);
            @(negedge clk);
        end
        cfg_wr_en = 1'b0;
        cur_sep = sp;
    endtask

    initial
    begin
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic [7:0]  sp;
        logic [31:0] ev;
        int          target;
        sb = new();
        calm = 1'b0;
        items_sent = 0;
        cur_sep = SEPARATOR_RESET;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extreme value, sign alone, blanks, zero byte, empty line, junk
        send_text("-2147483648");
        send_req(SEPARATOR_RESET, 1'b0);
        send_req(CHAR_PLUS, 1'b0);
        send_req(SEPARATOR_RESET, 1'b0);
        send_req(CHAR_VT, 1'b0);
        send_req(CHAR_FF, 1'b0);
        send_req(CHAR_CR, 1'b0);
        send_req(CHAR_TAB, 1'b0);
        send_req(CHAR_SPACE, 1'b0);
        send_text("5");
        send_req(CHAR_NUL, 1'b0);
        send_text("7");
        send_req(CHAR_NEWLINE, 1'b0);
        send_req(CHAR_NEWLINE, 1'b0);
        send_text("x1");
        send_end();

        for (int p = 0; p < 11; p++)
        begin
            case (p)
                0: begin sx = 8'd16;  sy = 8'd16;  sp = SEPARATOR_RESET; ev = 32'd0; end
                1: begin sx = 8'd0;   sy = 8'd0;   sp = CHAR_NUL;        ev = 32'hFFFF_FFFF; end
                2: begin sx = 8'd255; sy = 8'd255; sp = CHAR_NEWLINE;    ev = 32'd7; end
                3: begin sx = 8'd1;   sy = 8'd255; sp = 8'd255;          ev = 32'h8000_0000; end
                4: begin sx = 8'd255; sy = 8'd1;   sp = CHAR_SEMI;       ev = 32'h7FFF_FFFF; end
                default:
                begin
                    sx = 8'($urandom_range(0, 255));
                    sy = 8'($urandom_range(0, 255));
                    case ($urandom_range(0, 3))
                        0:       sp = SEPARATOR_RESET;
                        1:       sp = CHAR_SEMI;
                        2:       sp = CHAR_SPACE;
                        default: sp = 8'($urandom_range(0, 255));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        ev = $urandom;
                    else
                        ev = 32'($urandom_range(0, 10)) - 32'd5;
                end
            endcase
            drain();
            calm = (p % 4 == 3);
            write_regs(sx, sy, sp, ev);
            target = items_sent + 170;
            while (items_sent < target)
                send_field();
        end

        // large steps, then a short random tail
        drain();
        calm = 1'b1;
        write_regs(8'd255, 8'd255, SEPARATOR_RESET, 32'd0);
        send_text("7");
        send_req(SEPARATOR_RESET, 1'b0);
        send_text("-12");
        send_req(SEPARATOR_RESET, 1'b0);
        send_text("9");
        send_req(CHAR_NEWLINE, 1'b0);
        send_text("3");
        send_end();
        calm = 1'b0;
        repeat (40) send_field();

        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== delimited_grid_tile_parser_core.f =====
src/dgtp_pkg.sv
src/dgtp_field_conv.sv
src/delimited_grid_tile_parser_core.sv
dv/tb_delimited_grid_tile_parser_core.sv
